FILE: rtl/core/hpr_pkg.sv
// Shared types, byte codes and helpers for the hex packet receiver.
`timescale 1ns / 1ps

package hpr_pkg;

  // Width of payload counts and indexes (covers every supported payload size)
  localparam int PCNT_W = 6;
  // Entries in the job queue between parser and output sequencer
  localparam int QUEUE_DEPTH = 4;

  // Link byte codes
  localparam logic [7:0] B_DLE   = 8'h10;
  localparam logic [7:0] B_STX   = 8'h02;
  localparam logic [7:0] B_ACK   = 8'h1F;
  localparam logic [7:0] B_QUOTE = 8'h5C;
  localparam logic [7:0] B_EOF   = 8'hFF;
  localparam logic [7:0] B_CR    = 8'h0D;
  localparam logic [7:0] B_LF    = 8'h0A;
  localparam logic [7:0] ACK_XOR = 8'h71;

  // Checksum multiplier (octal 13215)
  localparam logic [15:0] SUM_MUL = 16'h168D;

  localparam logic [15:0] JUNK_LIMIT_RST = 16'd1000;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_EOF     = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_LINK = 2'd1;
  localparam logic [1:0] ERR_JUNK = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } hpr_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [1:0] error_code;
    logic       last;
  } hpr_out_t;

  typedef enum logic [1:0] {
    JOB_STORE,
    JOB_ERROR,
    JOB_DELIVER
  } job_op_t;

  // One job: store a payload byte, report an error, or deliver a packet
  typedef struct packed {
    job_op_t           op;
    logic [7:0]        value;  // payload byte, or hex char of the sequence
    logic [PCNT_W-1:0] cnt;    // store index, or payload byte count
    logic              eof;
    logic [1:0]        err;
  } hpr_job_t;

  typedef enum logic [3:0] {
    PS_HUNT,
    PS_TYPE,
    PS_SEQ,
    PS_LENH,
    PS_LENL,
    PS_PAY,
    PS_QHI,
    PS_QLO,
    PS_CK1,
    PS_CK2,
    PS_CK3,
    PS_CK4,
    PS_CR
  } parse_state_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_ACK,
    BS_PAY,
    BS_EOF
  } back_state_t;

  // Upper-case hex character of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] base;
    base = (v < 4'd10) ? 8'h30 : 8'h37;
    return base + {4'h0, v};
  endfunction

endpackage

FILE: rtl/core/hpr_job_queue.sv
// Short job queue between the packet parser and the output sequencer.
`timescale 1ns / 1ps

module hpr_job_queue
  import hpr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  hpr_job_t  wr_job,
  input  logic      pop,
  output hpr_job_t  rd_job,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  hpr_job_t         slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign rd_job = slots[rd_ptr];

  // Write the tail slot
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push && full |-> pop)
    else $error("job queue written while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("job queue read while empty");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    !push && !pop |=> $stable(count))
    else $error("job queue count moved without push or pop");

endmodule

FILE: rtl/core/hpr_front.sv
// Packet parser: takes link items, tracks framing and checksum, issues jobs.
`timescale 1ns / 1ps

module hpr_front
  import hpr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 50
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] junk_limit,
  input  logic        in_valid,
  output logic        in_stall,
  input  hpr_in_t     in_data,
  input  logic        q_full,
  output logic        push,
  output hpr_job_t    job
);

  parse_state_t      state, state_next;
  logic [15:0]       junk_count, junk_count_next;
  logic [3:0]        expected_seq, expected_seq_next;
  logic [15:0]       running_sum, running_sum_next;
  logic [PCNT_W-1:0] length_left, length_left_next;
  logic [PCNT_W-1:0] payload_count, payload_count_next;
  logic [3:0]        nibble_hold, nibble_hold_next;
  logic [15:0]       received_sum, received_sum_next;
  logic              eof_seen, eof_seen_next;
  logic              fold_pending, fold_pending_next;

  logic              accept;
  logic [7:0]        rx;
  logic              is_hex;
  logic [3:0]        hex_v;
  logic [7:0]        len;
  logic              len_ok;
  logic              take_data;
  logic [7:0]        dbyte;
  logic [PCNT_W-1:0] left_after;
  logic [7:0]        addend;
  logic [15:0]       sum_fold;
  logic [15:0]       rsum_shift;
  logic [15:0]       junk_inc;
  parse_state_t      fault_state;
  parse_state_t      data_state;

  // Hold input while the checksum takes its extra fold or the queue is full
  assign in_stall = fold_pending | q_full;
  assign accept   = in_valid & ~in_stall;
  assign rx       = in_data.rx_byte;

  // Decode upper-case hex digits
  assign is_hex = ((rx >= 8'h30) && (rx <= 8'h39)) || ((rx >= 8'h41) && (rx <= 8'h46));
  assign hex_v  = rx[6] ? (rx[3:0] + 4'd9) : rx[3:0];

  assign len    = {nibble_hold, hex_v};
  assign len_ok = is_hex && (len != 8'h00) && (len <= 8'(MAX_PAYLOAD));

  // Payload byte path, raw or from a quoted pair
  assign take_data  = ~in_data.cmd &&
                      (((state == PS_PAY) && (rx != B_QUOTE)) ||
                       ((state == PS_QLO) && is_hex));
  assign dbyte      = (state == PS_QLO) ? {nibble_hold, hex_v} : rx;
  assign left_after = length_left - PCNT_W'(1);

  // Shared checksum multiply-add
  assign addend   = fold_pending ? hex_char(expected_seq) : dbyte;
  assign sum_fold = 16'(running_sum * SUM_MUL) + {8'h00, addend};

  assign rsum_shift = {received_sum[11:0], hex_v};
  assign junk_inc   = junk_count + 16'd1;

  assign fault_state = (rx == B_DLE) ? PS_TYPE : PS_HUNT;

  // A stray end-of-file byte faults on the decoded byte, never a DLE
  always_comb begin
    if (dbyte == B_EOF) begin
      data_state = (left_after != '0) ? PS_HUNT : PS_CK1;
    end else begin
      data_state = (left_after != '0) ? PS_PAY : PS_CK1;
    end
  end

  // Next parse state
  always_comb begin
    state_next = state;
    if (accept) begin
      if (in_data.cmd) begin
        state_next = PS_HUNT;
      end else begin
        unique case (state)
          PS_HUNT: begin
            if (rx == B_DLE) state_next = PS_TYPE;
          end
          PS_TYPE: state_next = (rx == B_STX) ? PS_SEQ : fault_state;
          PS_SEQ:  state_next = is_hex ? PS_LENH : fault_state;
          PS_LENH: state_next = is_hex ? PS_LENL : fault_state;
          PS_LENL: state_next = len_ok ? PS_PAY : fault_state;
          PS_PAY:  state_next = (rx == B_QUOTE) ? PS_QHI : data_state;
          PS_QHI:  state_next = is_hex ? PS_QLO : fault_state;
          PS_QLO:  state_next = is_hex ? data_state : fault_state;
          PS_CK1:  state_next = is_hex ? PS_CK2 : fault_state;
          PS_CK2:  state_next = is_hex ? PS_CK3 : fault_state;
          PS_CK3:  state_next = is_hex ? PS_CK4 : fault_state;
          PS_CK4:  state_next = (is_hex && (rsum_shift == running_sum)) ? PS_CR : fault_state;
          PS_CR:   state_next = (rx == B_CR) ? PS_HUNT : fault_state;
          default: state_next = fault_state;
        endcase
      end
    end
  end

  // Datapath registers and job issue
  always_comb begin
    junk_count_next    = junk_count;
    expected_seq_next  = expected_seq;
    running_sum_next   = running_sum;
    length_left_next   = length_left;
    payload_count_next = payload_count;
    nibble_hold_next   = nibble_hold;
    received_sum_next  = received_sum;
    eof_seen_next      = eof_seen;
    fold_pending_next  = fold_pending;
    push               = 1'b0;
    job                = '0;

    if (fold_pending) begin
      // Fold the sequence character after the last payload byte
      running_sum_next  = sum_fold;
      fold_pending_next = 1'b0;
    end else if (accept) begin
      if (in_data.cmd) begin
        push               = 1'b1;
        job.op             = JOB_ERROR;
        job.err            = ERR_LINK;
        junk_count_next    = '0;
        eof_seen_next      = 1'b0;
        payload_count_next = '0;
      end else begin
        // Every way back to the hunt clears the junk count
        if (state != PS_HUNT) junk_count_next = '0;

        unique case (state)
          PS_HUNT: begin
            if (rx == B_DLE) begin
              junk_count_next = '0;
            end else if (junk_inc >= junk_limit) begin
              junk_count_next = '0;
              push            = 1'b1;
              job.op          = JOB_ERROR;
              job.err         = ERR_JUNK;
            end else begin
              junk_count_next = junk_inc;
            end
          end
          PS_LENH, PS_QHI: nibble_hold_next = hex_v;
          PS_LENL: begin
            if (len_ok) begin
              length_left_next   = len[PCNT_W-1:0];
              payload_count_next = '0;
              running_sum_next   = '0;
              eof_seen_next      = 1'b0;
            end
          end
          PS_CK1, PS_CK2, PS_CK3, PS_CK4: begin
            if (is_hex) received_sum_next = rsum_shift;
          end
          PS_CR: begin
            if (rx == B_CR) begin
              push               = 1'b1;
              job.op             = JOB_DELIVER;
              job.value          = hex_char(expected_seq);
              job.cnt            = payload_count;
              job.eof            = eof_seen;
              expected_seq_next  = expected_seq + 4'd1;
              eof_seen_next      = 1'b0;
              payload_count_next = '0;
            end
          end
          default: ;
        endcase

        if (take_data) begin
          running_sum_next = sum_fold;
          length_left_next = left_after;
          if (dbyte == B_EOF) begin
            eof_seen_next = 1'b1;
          end else begin
            push               = 1'b1;
            job.op             = JOB_STORE;
            job.value          = dbyte;
            job.cnt            = payload_count;
            payload_count_next = payload_count + PCNT_W'(1);
          end
          if (left_after == '0) begin
            fold_pending_next = 1'b1;
            received_sum_next = '0;
          end
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= PS_HUNT;
      junk_count    <= '0;
      expected_seq  <= '0;
      running_sum   <= '0;
      length_left   <= '0;
      payload_count <= '0;
      nibble_hold   <= '0;
      received_sum  <= '0;
      eof_seen      <= 1'b0;
      fold_pending  <= 1'b0;
    end else begin
      state         <= state_next;
      junk_count    <= junk_count_next;
      expected_seq  <= expected_seq_next;
      running_sum   <= running_sum_next;
      length_left   <= length_left_next;
      payload_count <= payload_count_next;
      nibble_hold   <= nibble_hold_next;
      received_sum  <= received_sum_next;
      eof_seen      <= eof_seen_next;
      fold_pending  <= fold_pending_next;
    end
  end

  a_fold_in_ck1 : assert property (@(posedge clk) disable iff (rst)
    fold_pending |-> (state == PS_CK1) && (received_sum == 16'h0000))
    else $error("checksum fold pending outside the first checksum digit");

  a_payload_left : assert property (@(posedge clk) disable iff (rst)
    (state == PS_PAY) || (state == PS_QHI) || (state == PS_QLO) |-> length_left != '0)
    else $error("payload state with no bytes left");

  a_store_in_range : assert property (@(posedge clk) disable iff (rst)
    push && (job.op == JOB_STORE) |-> job.cnt < PCNT_W'(MAX_PAYLOAD))
    else $error("payload store index out of range");

endmodule

FILE: rtl/core/hpr_back.sv
// Output sequencer: holds the payload store and plays jobs out as result items.
`timescale 1ns / 1ps

module hpr_back
  import hpr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 50
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  hpr_job_t  job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output hpr_out_t  out_data
);

  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]        store_mem [MAX_PAYLOAD];
  logic [7:0]        rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;

  back_state_t       bstate, bstate_next;
  logic [2:0]        step, step_next;
  logic [PCNT_W-1:0] pay_idx, pay_idx_next;
  logic [PCNT_W-1:0] pay_cnt;
  logic [7:0]        ack_h;
  logic              eof_flag;

  logic              can_load;
  logic              load;
  hpr_out_t          item;
  logic [7:0]        ack_byte;
  logic              pay_end;

  assign can_load = ~out_valid | ~out_stall;
  assign pay_end  = (pay_idx + PCNT_W'(1)) == pay_cnt;

  // Acknowledge bytes in order
  always_comb begin
    case (step)
      3'd0:    ack_byte = B_DLE;
      3'd1:    ack_byte = B_ACK;
      3'd2:    ack_byte = ack_h;
      3'd3:    ack_byte = ack_h ^ ACK_XOR;
      3'd4:    ack_byte = B_CR;
      default: ack_byte = B_LF;
    endcase
  end

  // Next sequencer state
  always_comb begin
    bstate_next = bstate;
    unique case (bstate)
      BS_IDLE: begin
        if (!q_empty && (job.op == JOB_DELIVER)) bstate_next = BS_ACK;
      end
      BS_ACK: begin
        if (can_load && (step == 3'd5)) begin
          if (pay_cnt != '0)  bstate_next = BS_PAY;
          else if (eof_flag)  bstate_next = BS_EOF;
          else                bstate_next = BS_IDLE;
        end
      end
      BS_PAY: begin
        if (can_load && pay_end) bstate_next = eof_flag ? BS_EOF : BS_IDLE;
      end
      BS_EOF: begin
        if (can_load) bstate_next = BS_IDLE;
      end
      default: bstate_next = BS_IDLE;
    endcase
  end

  // Job pop, store write and result item
  always_comb begin
    pop          = 1'b0;
    mem_we       = 1'b0;
    load         = 1'b0;
    item         = '0;
    step_next    = step;
    pay_idx_next = pay_idx;
    unique case (bstate)
      BS_IDLE: begin
        step_next    = '0;
        pay_idx_next = '0;
        if (!q_empty) begin
          unique case (job.op)
            JOB_STORE: begin
              pop    = 1'b1;
              mem_we = 1'b1;
            end
            JOB_ERROR: begin
              if (can_load) begin
                pop             = 1'b1;
                load            = 1'b1;
                item.kind       = KIND_ERROR;
                item.error_code = job.err;
                item.last       = 1'b1;
              end
            end
            JOB_DELIVER: pop = 1'b1;
            default: pop = 1'b1;
          endcase
        end
      end
      BS_ACK: begin
        load           = can_load;
        item.kind      = KIND_ACK;
        item.data_byte = ack_byte;
        item.last      = (step == 3'd5) && (pay_cnt == '0) && !eof_flag;
        if (can_load) step_next = step + 3'd1;
      end
      BS_PAY: begin
        load           = can_load;
        item.kind      = KIND_PAYLOAD;
        item.data_byte = rd_data;
        item.last      = pay_end && !eof_flag;
        if (can_load) pay_idx_next = pay_idx + PCNT_W'(1);
      end
      BS_EOF: begin
        load      = can_load;
        item.kind = KIND_EOF;
        item.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Read ahead at the next index so the byte is ready when it is due
  assign rd_addr = (pay_idx_next < PCNT_W'(MAX_PAYLOAD)) ? pay_idx_next[ADDR_W-1:0] : '0;

  // Payload store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[job.cnt[ADDR_W-1:0]] <= job.value;
    end
    rd_data <= store_mem[rd_addr];
  end

  // Latch the packet being delivered
  always_ff @(posedge clk) begin
    if (pop && (job.op == JOB_DELIVER)) begin
      ack_h    <= job.value;
      pay_cnt  <= job.cnt;
      eof_flag <= job.eof;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= BS_IDLE;
      step      <= '0;
      pay_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      bstate  <= bstate_next;
      step    <= step_next;
      pay_idx <= pay_idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= item;
    end
  end

  a_ack_step : assert property (@(posedge clk) disable iff (rst)
    bstate == BS_ACK |-> step <= 3'd5)
    else $error("acknowledge step past the line feed");

  a_pay_index : assert property (@(posedge clk) disable iff (rst)
    bstate == BS_PAY |-> pay_idx < pay_cnt)
    else $error("payload index past the byte count");

  a_eof_flag : assert property (@(posedge clk) disable iff (rst)
    bstate == BS_EOF |-> eof_flag)
    else $error("end-of-file item without end-of-file packet");

endmodule

FILE: rtl/core/hex_packet_receiver.sv
// Top level of the hex packet receiver: config register, parser, queue, sequencer.
// Path: with the sequencer idle, an error item goes from the job queue to the output register;
//   a packet's ack bytes follow its CR once the sequencer enters ACK, then one per cycle unless out_stall holds.
// Throughput: one input item per cycle; after the last payload byte input stalls
//   for the extra checksum fold, and it stalls while the four-entry job queue is full.
// Reset: rst is synchronous; it clears control state, junk_limit returns to 1000,
//   and the payload store is not cleared.
`timescale 1ns / 1ps

module hex_packet_receiver
  import hpr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 50
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  hpr_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output hpr_out_t    out_data
);

  logic [15:0] junk_limit;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;
  hpr_job_t    push_job;
  hpr_job_t    head_job;

  // Junk limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      junk_limit <= JUNK_LIMIT_RST;
    end else if (cfg_we) begin
      junk_limit <= cfg_wdata;
    end
  end

  hpr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .junk_limit (junk_limit),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_full     (q_full),
    .push       (q_push),
    .job        (push_job)
  );

  hpr_job_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (push_job),
    .pop    (q_pop),
    .rd_job (head_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  hpr_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .job       (head_job),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
